/* rtl/core/ecc_pkg.sv */
// ----------------------------------------------------------------------------
// ecc_pkg
// Shared types, constants and helper functions of the escape count colorizer.
// ----------------------------------------------------------------------------
package ecc_pkg;

   // sizes
   localparam int PAL_DEPTH       = 256;
   localparam int PAL_ADDR_BITS   = $clog2(PAL_DEPTH);
   localparam int COUNT_BITS      = 24;
   localparam int FRAC_BITS       = 16;
   localparam int LEVEL_FRAC_BITS = 12;
   localparam int CONTRAST        = 10;
   localparam int CH_BITS         = 8;
   localparam int NUM_CH          = 3;
   localparam int NUM_BITS        = 32;
   localparam int LEVEL_BITS      = 16;
   localparam int GAIN_BITS       = 20;
   localparam int PROD_BITS       = CH_BITS + FRAC_BITS + LEVEL_FRAC_BITS;
   localparam int HI_BITS         = PROD_BITS - FRAC_BITS;
   localparam int BLEND_BITS      = CH_BITS + FRAC_BITS + 1;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 16;
   localparam int SUM_BITS        = CH_BITS + 2;
   localparam int FOLD_BITS       = CH_BITS + 1;

   // channel slots in an rgb vector
   localparam int CH_RED   = 2;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 0;

   // request kinds
   localparam logic REQ_COLOR = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   localparam logic [GAIN_BITS-1:0] GAIN_ONE  = GAIN_BITS'(2 ** LEVEL_FRAC_BITS);
   localparam logic [FRAC_BITS:0]   FRAC_ONE  = (FRAC_BITS + 1)'(2 ** FRAC_BITS);
   localparam logic [FRAC_BITS-1:0] FRAC_TOP  = '1;

   typedef enum logic {
      MODE_GAIN    = 1'b0,
      MODE_PALETTE = 1'b1
   } ecc_mode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COLOR_MODE    = 3'd0,
      CSR_SMOOTH_ENABLE = 3'd1,
      CSR_RED_LEVEL     = 3'd2,
      CSR_GREEN_LEVEL   = 3'd3,
      CSR_BLUE_LEVEL    = 3'd4
   } ecc_csr_type;

   typedef logic [NUM_CH-1:0][CH_BITS-1:0] ecc_rgb_type;

   typedef struct packed {
      logic                  req_type;
      logic                  escaped;
      logic [COUNT_BITS-1:0] iter_count;
      logic [NUM_BITS-1:0]   eject_num;
      logic [NUM_BITS-1:0]   eject_den;
      logic [CH_BITS-1:0]    entry_index;
      logic [CH_BITS-1:0]    entry_red;
      logic [CH_BITS-1:0]    entry_green;
      logic [CH_BITS-1:0]    entry_blue;
   } ecc_req_type;

   typedef struct packed {
      logic [CH_BITS-1:0] pixel_red;
      logic [CH_BITS-1:0] pixel_green;
      logic [CH_BITS-1:0] pixel_blue;
   } ecc_rsp_type;

   typedef struct packed {
      ecc_mode_type                        color_mode;
      logic                                smooth_enable;
      logic [NUM_CH-1:0][GAIN_BITS-1:0]    gain;
   } ecc_cfg_type;

   // fields that ride along the divider
   typedef struct packed {
      logic                     is_write;
      logic                     escaped;
      logic [HI_BITS-1:0]       count_lo;
      logic [PAL_ADDR_BITS-1:0] pal_addr;
      logic [PAL_ADDR_BITS-1:0] entry_index;
      ecc_rgb_type              entry_rgb;
   } ecc_side_type;

   typedef struct packed {
      logic [NUM_BITS-1:0]  rem;
      logic [NUM_BITS-1:0]  den;
      logic [FRAC_BITS-1:0] quo;
      logic                 zero;
      logic                 sat;
      ecc_side_type         side;
   } ecc_div_type;

   // gain = 1 + contrast * level, unsigned q.12
   function automatic logic [GAIN_BITS-1:0] level_gain(input logic [LEVEL_BITS-1:0] level);
      logic [GAIN_BITS-1:0] lvl;
      lvl = GAIN_BITS'(level);
      return GAIN_BITS'(GAIN_BITS'(CONTRAST) * lvl) + GAIN_ONE;
   endfunction

   // count mod 255 by byte folding, entry 0 for inside points
   function automatic logic [PAL_ADDR_BITS-1:0] pal_index(input logic [COUNT_BITS-1:0] count,
                                                          input logic escaped);
      logic [SUM_BITS-1:0]  sum;
      logic [FOLD_BITS-1:0] fold;
      sum  = SUM_BITS'(count[23:16]) + SUM_BITS'(count[15:8]) + SUM_BITS'(count[7:0]);
      fold = FOLD_BITS'(sum[SUM_BITS-1:CH_BITS]) + FOLD_BITS'(sum[CH_BITS-1:0]);
      if (fold >= FOLD_BITS'(PAL_DEPTH - 1)) begin
         fold = fold - FOLD_BITS'(PAL_DEPTH - 1);
      end
      if (!escaped) begin
         fold = '0;
      end
      return fold[PAL_ADDR_BITS-1:0];
   endfunction

   // ramp held by entries never written
   function automatic ecc_rgb_type pal_default(input logic [PAL_ADDR_BITS-1:0] addr);
      ecc_rgb_type rgb;
      rgb[CH_RED]   = CH_BITS'(addr);
      rgb[CH_GREEN] = CH_BITS'(addr);
      rgb[CH_BLUE]  = CH_BITS'({addr, 2'b00});
      return rgb;
   endfunction

endpackage

/* rtl/core/escape_count_colorizer_top.sv */
// ----------------------------------------------------------------------------
// escape_count_colorizer_top
// Turns fractal escape counts into rgb pixels or loads palette entries.
//
// A request word on req_ (valid/stall) either colorizes one point or writes
// one palette entry. Every colorize word gives one pixel word on rsp_; a
// palette write gives none. Words come out in request order.
// From acceptance to rsp_valid a word passes one entry stage, 16
// divider stages (one quotient bit each), two color stages and the result
// register. One word is accepted every cycle while req_stall is low; the
// pipelined divider sets the depth and the single palette write port keeps
// writes in order with reads.
// The csr_ port writes color mode, smoothing and the three channel levels;
// the user must use it only while no word is in flight (not enforced).
// Reset empties the pipeline, loads the default registers and makes every
// palette entry read as the default ramp until it is written.
// While rsp_stall holds a pixel, the stages behind it keep filling empty
// slots and req_stall rises only when the pipeline is full.
// ----------------------------------------------------------------------------
module escape_count_colorizer_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ecc_pkg::ecc_req_type                req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ecc_pkg::ecc_rsp_type                rsp_word,
   input  logic                                csr_write,
   input  logic [ecc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ecc_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   ecc_pkg::ecc_cfg_type   cfg;
   ecc_pkg::ecc_side_type  side;
   ecc_pkg::ecc_div_type   div_data;
   logic                   div_valid;
   logic                   div_ready;
   logic                   shade_ready;
   logic                   req_ready;

   ecc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   always_comb begin
      side.is_write              = (req_word.req_type == ecc_pkg::REQ_WRITE);
      side.escaped               = req_word.escaped;
      side.count_lo              = req_word.iter_count[ecc_pkg::HI_BITS-1:0];
      side.pal_addr              = ecc_pkg::pal_index(req_word.iter_count, req_word.escaped);
      side.entry_index           = req_word.entry_index[ecc_pkg::PAL_ADDR_BITS-1:0];
      side.entry_rgb[ecc_pkg::CH_RED]   = req_word.entry_red;
      side.entry_rgb[ecc_pkg::CH_GREEN] = req_word.entry_green;
      side.entry_rgb[ecc_pkg::CH_BLUE]  = req_word.entry_blue;
   end

   ecc_frac_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_num    (req_word.eject_num),
      .in_den    (req_word.eject_den),
      .in_side   (side),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   ecc_shade u_shade (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (div_valid),
      .in_ready  (shade_ready),
      .in_data   (div_data),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_word  (rsp_word)
   );

   assign div_ready = shade_ready;
   assign req_stall = !req_ready;

endmodule

/* rtl/core/ecc_csr.sv */
// ----------------------------------------------------------------------------
// ecc_csr
// Configuration registers; channel levels are kept as ready-made gains.
// ----------------------------------------------------------------------------
module ecc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [ecc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ecc_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output ecc_pkg::ecc_cfg_type                cfg
);

   ecc_pkg::ecc_cfg_type cfg_ff;
   ecc_pkg::ecc_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            ecc_pkg::CSR_COLOR_MODE: begin
               cfg_in.color_mode = ecc_pkg::ecc_mode_type'(csr_wdata[0]);
            end
            ecc_pkg::CSR_SMOOTH_ENABLE: begin
               cfg_in.smooth_enable = csr_wdata[0];
            end
            ecc_pkg::CSR_RED_LEVEL: begin
               cfg_in.gain[ecc_pkg::CH_RED] = ecc_pkg::level_gain(csr_wdata);
            end
            ecc_pkg::CSR_GREEN_LEVEL: begin
               cfg_in.gain[ecc_pkg::CH_GREEN] = ecc_pkg::level_gain(csr_wdata);
            end
            ecc_pkg::CSR_BLUE_LEVEL: begin
               cfg_in.gain[ecc_pkg::CH_BLUE] = ecc_pkg::level_gain(csr_wdata);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.color_mode              <= ecc_pkg::MODE_GAIN;
         cfg_ff.smooth_enable           <= 1'b0;
         cfg_ff.gain[ecc_pkg::CH_RED]   <= ecc_pkg::level_gain(ecc_pkg::CSR_DATA_BITS'(4096));
         cfg_ff.gain[ecc_pkg::CH_GREEN] <= ecc_pkg::level_gain('0);
         cfg_ff.gain[ecc_pkg::CH_BLUE]  <= ecc_pkg::level_gain('0);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/ecc_frac_div.sv */
// ----------------------------------------------------------------------------
// ecc_frac_div
// Pipelined restoring divider: one quotient bit of num * 2^16 / den per stage.
// ----------------------------------------------------------------------------
module ecc_frac_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [ecc_pkg::NUM_BITS-1:0]   in_num,
   input  logic [ecc_pkg::NUM_BITS-1:0]   in_den,
   input  ecc_pkg::ecc_side_type          in_side,
   output logic                           out_valid,
   input  logic                           out_ready,
   output ecc_pkg::ecc_div_type           out_data
);

   ecc_pkg::ecc_div_type stage_ff [ecc_pkg::FRAC_BITS+1];
   logic                 valid_ff [ecc_pkg::FRAC_BITS+1];
   logic                 ready    [ecc_pkg::FRAC_BITS+1];
   ecc_pkg::ecc_div_type first_in;

   // entry stage: flags for zero and saturating ratios
   always_comb begin
      first_in.rem  = in_num;
      first_in.den  = in_den;
      first_in.quo  = '0;
      first_in.zero = (in_den == '0);
      first_in.sat  = (in_num >= in_den);
      first_in.side = in_side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (ready[0]) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         stage_ff[0] <= first_in;
      end
   end

   genvar k;
   for (k = 1; k <= ecc_pkg::FRAC_BITS; k++) begin : g_step
      logic [ecc_pkg::NUM_BITS:0] shifted;
      logic [ecc_pkg::NUM_BITS:0] diff;
      logic                       fits;
      ecc_pkg::ecc_div_type       step_in;

      always_comb begin
         shifted      = {stage_ff[k-1].rem, 1'b0};
         diff         = shifted - {1'b0, stage_ff[k-1].den};
         fits         = (shifted >= {1'b0, stage_ff[k-1].den});
         step_in      = stage_ff[k-1];
         step_in.rem  = fits ? diff[ecc_pkg::NUM_BITS-1:0] : shifted[ecc_pkg::NUM_BITS-1:0];
         step_in.quo  = {stage_ff[k-1].quo[ecc_pkg::FRAC_BITS-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (ready[k]) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (ready[k]) begin
            stage_ff[k] <= step_in;
         end
      end
   end

   for (k = 0; k < ecc_pkg::FRAC_BITS; k++) begin : g_ready
      assign ready[k] = !valid_ff[k] || ready[k+1];
   end
   assign ready[ecc_pkg::FRAC_BITS] = !valid_ff[ecc_pkg::FRAC_BITS] || out_ready;

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[ecc_pkg::FRAC_BITS];
   assign out_data  = stage_ff[ecc_pkg::FRAC_BITS];

endmodule

/* rtl/core/ecc_palette.sv */
// ----------------------------------------------------------------------------
// ecc_palette
// Palette memory, one write and two registered reads; unwritten entries
// read as the default ramp
// ----------------------------------------------------------------------------
module ecc_palette (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               rd_en,
   input  logic [ecc_pkg::PAL_ADDR_BITS-1:0]  rd_addr0,
   input  logic [ecc_pkg::PAL_ADDR_BITS-1:0]  rd_addr1,
   input  logic                               wr_en,
   input  logic [ecc_pkg::PAL_ADDR_BITS-1:0]  wr_addr,
   input  ecc_pkg::ecc_rgb_type               wr_data,
   output ecc_pkg::ecc_rgb_type               rd_data0,
   output ecc_pkg::ecc_rgb_type               rd_data1
);

   ecc_pkg::ecc_rgb_type                  mem [ecc_pkg::PAL_DEPTH];
   logic [ecc_pkg::PAL_DEPTH-1:0]         written_ff;
   ecc_pkg::ecc_rgb_type                  q0_ff;
   ecc_pkg::ecc_rgb_type                  q1_ff;
   logic                                  ok0_ff;
   logic                                  ok1_ff;
   logic [ecc_pkg::PAL_ADDR_BITS-1:0]     addr0_ff;
   logic [ecc_pkg::PAL_ADDR_BITS-1:0]     addr1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         q0_ff    <= mem[rd_addr0];
         q1_ff    <= mem[rd_addr1];
         ok0_ff   <= written_ff[rd_addr0];
         ok1_ff   <= written_ff[rd_addr1];
         addr0_ff <= rd_addr0;
         addr1_ff <= rd_addr1;
      end
   end

   assign rd_data0 = ok0_ff ? q0_ff : ecc_pkg::pal_default(addr0_ff);
   assign rd_data1 = ok1_ff ? q1_ff : ecc_pkg::pal_default(addr1_ff);

endmodule

/* rtl/core/ecc_shade.sv */
// ----------------------------------------------------------------------------
// ecc_shade
// Color stages: gain products and palette read, sums and blend products,
// then the result register.
// ----------------------------------------------------------------------------
module ecc_shade (
   input  logic                   clock,
   input  logic                   reset,
   input  ecc_pkg::ecc_cfg_type   cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  ecc_pkg::ecc_div_type   in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output ecc_pkg::ecc_rsp_type   out_word
);

   localparam int NC = ecc_pkg::NUM_CH;

   // stage a
   logic                                        a_valid_ff;
   logic                                        a_write_ff;
   logic                                        a_escaped_ff;
   logic [ecc_pkg::FRAC_BITS-1:0]               a_frac_ff;
   logic [NC-1:0][ecc_pkg::HI_BITS-1:0]         a_hi_ff;
   logic [NC-1:0][ecc_pkg::PROD_BITS-1:0]       a_lo_ff;
   logic [ecc_pkg::FRAC_BITS-1:0]               a_frac_in;
   logic [NC-1:0][ecc_pkg::HI_BITS-1:0]         a_hi_in;
   logic [NC-1:0][ecc_pkg::PROD_BITS-1:0]       a_lo_in;
   logic                                        a_ready;
   ecc_pkg::ecc_rgb_type                        entry0;
   ecc_pkg::ecc_rgb_type                        entry1;

   // stage b
   logic                                        b_valid_ff;
   logic                                        b_write_ff;
   logic                                        b_escaped_ff;
   ecc_pkg::ecc_rgb_type                        b_gain_ff;
   logic [NC-1:0][ecc_pkg::BLEND_BITS-1:0]      b_p0_ff;
   logic [NC-1:0][ecc_pkg::BLEND_BITS-1:0]      b_p1_ff;
   ecc_pkg::ecc_rgb_type                        b_gain_in;
   logic [NC-1:0][ecc_pkg::BLEND_BITS-1:0]      b_p0_in;
   logic [NC-1:0][ecc_pkg::BLEND_BITS-1:0]      b_p1_in;
   logic [ecc_pkg::FRAC_BITS:0]                 b_weight;
   logic [ecc_pkg::PROD_BITS-1:0]               b_sum [NC];
   logic                                        b_ready;

   // result stage
   logic                                        c_valid_ff;
   ecc_pkg::ecc_rgb_type                        c_pixel_ff;
   ecc_pkg::ecc_rgb_type                        c_pixel_in;
   logic [ecc_pkg::BLEND_BITS-1:0]              c_sum [NC];
   logic                                        c_ready;

   assign c_ready  = !c_valid_ff || out_ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   // fraction: zero denominator, saturation, smoothing off, inside point
   always_comb begin
      if (in_data.zero || !cfg.smooth_enable || !in_data.side.escaped) begin
         a_frac_in = '0;
      end else if (in_data.sat) begin
         a_frac_in = ecc_pkg::FRAC_TOP;
      end else begin
         a_frac_in = in_data.quo;
      end
      for (int c = 0; c < NC; c++) begin
         a_hi_in[c] = ecc_pkg::HI_BITS'(in_data.side.count_lo * cfg.gain[c]);
         a_lo_in[c] = ecc_pkg::PROD_BITS'(a_frac_in) * ecc_pkg::PROD_BITS'(cfg.gain[c]);
      end
   end

   ecc_palette u_palette (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (a_ready),
      .rd_addr0 (in_data.side.pal_addr),
      .rd_addr1 (in_data.side.pal_addr + ecc_pkg::PAL_ADDR_BITS'(1)),
      .wr_en    (a_ready && in_valid && in_data.side.is_write),
      .wr_addr  (in_data.side.entry_index),
      .wr_data  (in_data.side.entry_rgb),
      .rd_data0 (entry0),
      .rd_data1 (entry1)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_write_ff   <= in_data.side.is_write;
         a_escaped_ff <= in_data.side.escaped;
         a_frac_ff    <= a_frac_in;
         a_hi_ff      <= a_hi_in;
         a_lo_ff      <= a_lo_in;
      end
   end

   // gain sums and blend products
   always_comb begin
      b_weight = ecc_pkg::FRAC_ONE - {1'b0, a_frac_ff};
      for (int c = 0; c < NC; c++) begin
         b_sum[c]     = {a_hi_ff[c], ecc_pkg::FRAC_BITS'(0)} + a_lo_ff[c];
         b_gain_in[c] = b_sum[c][ecc_pkg::PROD_BITS-1 -: ecc_pkg::CH_BITS];
         b_p0_in[c]   = ecc_pkg::BLEND_BITS'(entry0[c]) * ecc_pkg::BLEND_BITS'(b_weight);
         b_p1_in[c]   = ecc_pkg::BLEND_BITS'(entry1[c]) * ecc_pkg::BLEND_BITS'(a_frac_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready) begin
         b_write_ff   <= a_write_ff;
         b_escaped_ff <= a_escaped_ff;
         b_gain_ff    <= b_gain_in;
         b_p0_ff      <= b_p0_in;
         b_p1_ff      <= b_p1_in;
      end
   end

   // blend sum and mode select
   always_comb begin
      for (int c = 0; c < NC; c++) begin
         c_sum[c] = b_p0_ff[c] + b_p1_ff[c];
         if (cfg.color_mode == ecc_pkg::MODE_PALETTE) begin
            c_pixel_in[c] = c_sum[c][ecc_pkg::FRAC_BITS +: ecc_pkg::CH_BITS];
         end else if (b_escaped_ff) begin
            c_pixel_in[c] = b_gain_ff[c];
         end else begin
            c_pixel_in[c] = '0;
         end
      end
   end

   // palette writes leave the pipe here without a word
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_ready) begin
         c_valid_ff <= b_valid_ff && !b_write_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (c_ready) begin
         c_pixel_ff <= c_pixel_in;
      end
   end

   assign out_valid            = c_valid_ff;
   assign out_word.pixel_red   = c_pixel_ff[ecc_pkg::CH_RED];
   assign out_word.pixel_green = c_pixel_ff[ecc_pkg::CH_GREEN];
   assign out_word.pixel_blue  = c_pixel_ff[ecc_pkg::CH_BLUE];

endmodule
